// File: hdl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

  // Default widths of the position and length counters
  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF = 8;

  // Record queue between scanner and output stage
  localparam int unsigned QUEUE_DEPTH = 4;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_IDENT  = 3'd2,
    MODE_STRING = 3'd3,
    MODE_ERROR  = 3'd4
  } scan_mode_e;

  // Token kinds as they appear on the output
  typedef enum logic [3:0] {
    KIND_NUMBER    = 4'd0,
    KIND_KEYWORD   = 4'd1,
    KIND_IDENT     = 4'd2,
    KIND_STRING    = 4'd3,
    KIND_OPERATOR  = 4'd4,
    KIND_LPAREN    = 4'd5,
    KIND_RPAREN    = 4'd6,
    KIND_SEMICOLON = 4'd7,
    KIND_COMMA     = 4'd8,
    KIND_ERROR     = 4'd9
  } token_kind_e;

  // Operator codes
  typedef enum logic [1:0] {
    OP_PLUS   = 2'd0,
    OP_MINUS  = 2'd1,
    OP_TIMES  = 2'd2,
    OP_DIVIDE = 2'd3
  } op_code_e;

  // Character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Keyword "fun": progress value once all three bytes matched
  localparam logic [1:0] KW_DONE = 2'd3;

  // Queue status seen by the scanner and the output stage
  typedef struct packed {
    logic room_for_two;
    logic has_data;
  } queue_stat_t;

  function automatic logic [7:0] kw_char(input logic [1:0] prog);
    logic [7:0] ch;
    case (prog)
      2'd0:    ch = 8'h66;  // f
      2'd1:    ch = 8'h75;  // u
      default: ch = 8'h6E;  // n
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// File: hdl/stt_front.sv
`timescale 1ns / 1ps

// Scanner: classifies each accepted byte, keeps token state and
// produces up to two records per transaction into the queue.
module stt_front #(
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  localparam int unsigned PW = OFFSET_BITS + LENGTH_BITS + 11,
  localparam int unsigned RW = PW + 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    in_end_i,
  input  stt_pkg::queue_stat_t    q_stat_i,
  output logic                    push0_o,
  output logic                    push1_o,
  output logic [RW-1:0]           rec0_o,
  output logic [RW-1:0]           rec1_o
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  stt_pkg::scan_mode_e     mode_q, mode_d;
  logic [OFFSET_BITS-1:0]  off_q, off_d;
  logic [OFFSET_BITS-1:0]  start_q, start_d;
  logic [LENGTH_BITS-1:0]  cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic [1:0]              kp_q, kp_d;
  logic                    ksp_q, ksp_d;

  logic                    accept;
  logic [OFFSET_BITS-1:0]  pos_inc;
  logic [LENGTH_BITS-1:0]  cnt_grow;
  logic                    ovf_grow;
  logic                    pending;
  stt_pkg::token_kind_e    flush_kind;
  logic                    flush_v, new_v, scan_new;
  stt_pkg::token_kind_e    new_kind;
  stt_pkg::op_code_e       new_op;
  logic [7:0]              new_bad;
  logic [RW-1:0]           flush_rec, new_rec;

  assign in_ready_o = q_stat_i.room_for_two;
  assign accept     = in_valid_i & in_ready_o;
  assign pos_inc    = off_q + OFFSET_BITS'(1);

  // Saturating length update
  assign cnt_grow = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + LENGTH_BITS'(1);
  assign ovf_grow = ovf_q | (cnt_q == LEN_MAX);

  // Kind of the pending multi-byte token
  always_comb begin
    pending    = 1'b1;
    flush_kind = stt_pkg::KIND_NUMBER;
    case (mode_q)
      stt_pkg::MODE_NUMBER: flush_kind = stt_pkg::KIND_NUMBER;
      stt_pkg::MODE_IDENT: begin
        flush_kind = (ksp_q && (kp_q == stt_pkg::KW_DONE)) ? stt_pkg::KIND_KEYWORD
                                                            : stt_pkg::KIND_IDENT;
      end
      stt_pkg::MODE_STRING: flush_kind = stt_pkg::KIND_STRING;
      default: pending = 1'b0;
    endcase
  end

  // Next state and record selection
  always_comb begin
    mode_d   = mode_q;
    off_d    = off_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    kp_d     = kp_q;
    ksp_d    = ksp_q;
    flush_v  = 1'b0;
    new_v    = 1'b0;
    scan_new = 1'b0;
    new_kind = stt_pkg::KIND_NUMBER;
    new_op   = stt_pkg::OP_PLUS;
    new_bad  = 8'h00;
    if (accept) begin
      if (in_end_i) begin
        // end of input: flush and restart
        flush_v = pending;
        mode_d  = stt_pkg::MODE_IDLE;
        off_d   = '0;
        start_d = '0;
        cnt_d   = '0;
        ovf_d   = 1'b0;
        kp_d    = 2'd0;
        ksp_d   = 1'b0;
      end else begin
        off_d = pos_inc;
        case (mode_q)
          stt_pkg::MODE_ERROR: begin
            mode_d = stt_pkg::MODE_ERROR;
          end
          stt_pkg::MODE_NUMBER: begin
            if (stt_pkg::is_digit(in_byte_i)) begin
              cnt_d = cnt_grow;
              ovf_d = ovf_grow;
            end else begin
              flush_v  = 1'b1;
              scan_new = 1'b1;
            end
          end
          stt_pkg::MODE_IDENT: begin
            if (stt_pkg::is_alpha(in_byte_i) || stt_pkg::is_digit(in_byte_i)) begin
              cnt_d = cnt_grow;
              ovf_d = ovf_grow;
              if (ksp_q && (kp_q != stt_pkg::KW_DONE) &&
                  (in_byte_i == stt_pkg::kw_char(kp_q))) begin
                kp_d = kp_q + 2'd1;
              end else begin
                ksp_d = 1'b0;
              end
            end else begin
              flush_v  = 1'b1;
              scan_new = 1'b1;
            end
          end
          stt_pkg::MODE_STRING: begin
            if (in_byte_i == stt_pkg::CH_QUOTE) begin
              flush_v = 1'b1;
              mode_d  = stt_pkg::MODE_IDLE;
            end else begin
              cnt_d = cnt_grow;
              ovf_d = ovf_grow;
            end
          end
          default: scan_new = 1'b1;
        endcase

        // byte scanned from idle
        if (scan_new) begin
          mode_d = stt_pkg::MODE_IDLE;
          if (stt_pkg::is_space(in_byte_i)) begin
            mode_d = stt_pkg::MODE_IDLE;
          end else if (stt_pkg::is_digit(in_byte_i) || stt_pkg::is_alpha(in_byte_i)) begin
            mode_d  = stt_pkg::is_digit(in_byte_i) ? stt_pkg::MODE_NUMBER
                                                   : stt_pkg::MODE_IDENT;
            start_d = off_q;
            cnt_d   = LENGTH_BITS'(1);
            ovf_d   = 1'b0;
            ksp_d   = (in_byte_i == stt_pkg::kw_char(2'd0));
            kp_d    = {1'b0, (in_byte_i == stt_pkg::kw_char(2'd0))};
          end else if (in_byte_i == stt_pkg::CH_QUOTE) begin
            mode_d  = stt_pkg::MODE_STRING;
            start_d = pos_inc;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            new_v = 1'b1;
            case (in_byte_i)
              stt_pkg::CH_PLUS: begin
                new_kind = stt_pkg::KIND_OPERATOR;
                new_op   = stt_pkg::OP_PLUS;
              end
              stt_pkg::CH_MINUS: begin
                new_kind = stt_pkg::KIND_OPERATOR;
                new_op   = stt_pkg::OP_MINUS;
              end
              stt_pkg::CH_STAR: begin
                new_kind = stt_pkg::KIND_OPERATOR;
                new_op   = stt_pkg::OP_TIMES;
              end
              stt_pkg::CH_SLASH: begin
                new_kind = stt_pkg::KIND_OPERATOR;
                new_op   = stt_pkg::OP_DIVIDE;
              end
              stt_pkg::CH_LPAREN: new_kind = stt_pkg::KIND_LPAREN;
              stt_pkg::CH_RPAREN: new_kind = stt_pkg::KIND_RPAREN;
              stt_pkg::CH_SEMI:   new_kind = stt_pkg::KIND_SEMICOLON;
              stt_pkg::CH_COMMA:  new_kind = stt_pkg::KIND_COMMA;
              default: begin
                new_kind = stt_pkg::KIND_ERROR;
                new_bad  = in_byte_i;
                mode_d   = stt_pkg::MODE_ERROR;
              end
            endcase
          end
        end
      end
    end
  end

  // Record layout: {last, kind, bad, op, sat, len, start}
  assign flush_rec = {~new_v, flush_kind, 8'h00, stt_pkg::OP_PLUS, ovf_q, cnt_q, start_q};
  assign new_rec   = {1'b1, new_kind, new_bad, new_op, 1'b0, LENGTH_BITS'(1), off_q};

  // Flush record goes first when both are present
  assign push0_o = flush_v | new_v;
  assign push1_o = flush_v & new_v;
  assign rec0_o  = flush_v ? flush_rec : new_rec;
  assign rec1_o  = new_rec;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      off_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      kp_q    <= 2'd0;
      ksp_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      off_q   <= off_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      kp_q    <= kp_d;
      ksp_q   <= ksp_d;
    end
  end

endmodule

// File: hdl/stt_queue.sv
`timescale 1ns / 1ps

// Record queue: two pushes and one pop per cycle.
module stt_queue #(
  parameter int unsigned RW = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push0_i,
  input  logic                 push1_i,
  input  logic [RW-1:0]        rec0_i,
  input  logic [RW-1:0]        rec1_i,
  input  logic                 pop_i,
  output logic [RW-1:0]        head_o,
  output stt_pkg::queue_stat_t stat_o
);

  localparam int unsigned DEPTH = stt_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [RW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + AW'(1);
  assign wr_ptr_d  = wr_ptr_q + AW'(push0_i) + AW'(push1_i);
  assign rd_ptr_d  = rd_ptr_q + AW'(pop_i);
  assign cnt_d     = cnt_q + CW'(push0_i) + CW'(push1_i) - CW'(pop_i);

  assign head_o              = mem_q[rd_ptr_q];
  assign stat_o.has_data     = (cnt_q != '0);
  assign stat_o.room_for_two = (cnt_q <= CW'(DEPTH - 2));

  // Storage
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= rec0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nx] <= rec1_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/stt_back.sv
`timescale 1ns / 1ps

// Output stage: pops records and holds them on the master side.
module stt_back #(
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  localparam int unsigned PW  = OFFSET_BITS + LENGTH_BITS + 11,
  localparam int unsigned RW  = PW + 5,
  localparam int unsigned TDW = ((PW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stt_pkg::queue_stat_t q_stat_i,
  input  logic [RW-1:0]        head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TDW-1:0]       out_data_o,
  output logic [3:0]           out_kind_o,
  output logic                 out_last_o
);

  logic          vld_q, vld_d;
  logic [RW-1:0] rec_q;

  // Load when the register is empty or being drained
  assign pop_o = q_stat_i.has_data & (~vld_q | out_ready_i);

  always_comb begin
    vld_d = vld_q;
    if (pop_o) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= head_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = TDW'(rec_q[PW-1:0]);
  assign out_kind_o  = rec_q[PW+3:PW];
  assign out_last_o  = rec_q[PW+4];

endmodule

// File: hdl/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata                          tuser       tlast
// s_axis   in   byte_value                     -           end_marker
// m_axis   out  start_offset, token_length,    token_kind  last_of_run
//               length_saturated, operator_code,
//               offending_byte
//
// One byte per cycle in while s_axis_tready is high; each byte is scanned in
// the cycle it is accepted. Records leave one per cycle while m_axis_tready
// is high, through a 4-entry queue and then an output register.
// A byte can cause two records; the 4-entry queue absorbs the second.
// s_axis_tready drops while fewer than two queue entries are free.
// Reset clears the scanner to idle at offset zero and empties the queue.
module source_text_tokenizer_unit #(
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  localparam int unsigned PW  = OFFSET_BITS + LENGTH_BITS + 11,
  localparam int unsigned TDW = ((PW + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // byte_value
  input  logic           s_axis_tlast,   // end_marker
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // start_offset, token_length, length_saturated, operator_code, offending_byte
  output logic [TDW-1:0] m_axis_tdata,
  output logic [3:0]     m_axis_tuser,   // token_kind
  output logic           m_axis_tlast    // last_of_run
);

  localparam int unsigned RW = PW + 5;

  stt_pkg::queue_stat_t q_stat;
  logic                 push0, push1, pop;
  logic [RW-1:0]        rec0, rec1, head;

  stt_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_stat_i   (q_stat),
    .push0_o    (push0),
    .push1_o    (push1),
    .rec0_o     (rec0),
    .rec1_o     (rec1)
  );

  stt_queue #(
    .RW (RW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .rec0_i  (rec0),
    .rec1_i  (rec1),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  stt_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: hdl/stt_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the record stream
module stt_checker #(
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  localparam int unsigned PW  = OFFSET_BITS + LENGTH_BITS + 11,
  localparam int unsigned TDW = ((PW + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic [7:0]     s_axis_tdata,
  input logic           s_axis_tlast,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic [3:0]     m_axis_tuser,
  input logic           m_axis_tlast
);

  localparam int unsigned SAT_BIT = OFFSET_BITS + LENGTH_BITS;
  localparam int unsigned OP_LSB  = SAT_BIT + 1;
  localparam int unsigned BAD_LSB = OP_LSB + 2;

  logic [LENGTH_BITS-1:0] len;
  logic                   sat;
  logic [1:0]             op;
  logic [7:0]             bad;
  logic                   single;
  logic                   in_seen;

  assign len    = m_axis_tdata[SAT_BIT-1:OFFSET_BITS];
  assign sat    = m_axis_tdata[SAT_BIT];
  assign op     = m_axis_tdata[OP_LSB+1:OP_LSB];
  assign bad    = m_axis_tdata[BAD_LSB+7:BAD_LSB];
  assign in_seen = s_axis_tvalid & s_axis_tready & (s_axis_tlast | (s_axis_tdata != 8'h00))
                   | ~(s_axis_tvalid & s_axis_tready);
  assign single = (m_axis_tuser == stt_pkg::KIND_OPERATOR) ||
                  (m_axis_tuser == stt_pkg::KIND_LPAREN) ||
                  (m_axis_tuser == stt_pkg::KIND_RPAREN) ||
                  (m_axis_tuser == stt_pkg::KIND_SEMICOLON) ||
                  (m_axis_tuser == stt_pkg::KIND_COMMA);

  // A stalled record stays offered (checked while in_seen)
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && in_seen |=> m_axis_tvalid)
    else $error("record dropped while stalled");

  // Only error records carry an offending byte
  a_bad_only_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != stt_pkg::KIND_ERROR) |-> bad == 8'h00)
    else $error("offending byte on non-error record");

  // Operator code only on operator records
  a_op_only_oper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != stt_pkg::KIND_OPERATOR) |-> op == stt_pkg::OP_PLUS)
    else $error("operator code on non-operator record");

  // Single-byte tokens and errors are length one, never saturated
  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (single || (m_axis_tuser == stt_pkg::KIND_ERROR))
      |-> (len == LENGTH_BITS'(1)) && !sat)
    else $error("single-byte record with wrong length");

endmodule

bind source_text_tokenizer_unit stt_checker #(
  .OFFSET_BITS (OFFSET_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_stt_checker (.*);

// File: dv/source_text_tokenizer_unit_tb.sv
`timescale 1ns / 1ps

module source_text_tokenizer_unit_tb;

  localparam int OFF_W = 16;
  localparam int LEN_W = 8;
  localparam int TDW = ((OFF_W + LEN_W + 11 + 7) / 8) * 8;

  // tdata field positions, lowest first
  localparam int LEN_LSB = OFF_W;
  localparam int SAT_BIT = OFF_W + LEN_W;
  localparam int OP_LSB  = SAT_BIT + 1;
  localparam int BAD_LSB = OP_LSB + 2;
  localparam int PAD_LSB = BAD_LSB + 8;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_ITEMS     = 110;

  // "fun", first byte lowest
  localparam logic [23:0] KW_TEXT = {8'h6E, 8'h75, 8'h66};

  typedef struct packed {
    stt_pkg::token_kind_e kind;
    logic [OFF_W-1:0]     start;
    logic [LEN_W-1:0]     len;
    logic                 sat;
    stt_pkg::op_code_e    op;
    logic [7:0]           bad;
    logic                 last;
  } tok_rec_t;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    tok_rec_t   exp;
  } dir_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [7:0]     s_axis_tdata;
  logic           s_axis_tlast;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [TDW-1:0] m_axis_tdata;
  logic [3:0]     m_axis_tuser;
  logic           m_axis_tlast;

  source_text_tokenizer_unit #(
    .OFFSET_BITS(OFF_W),
    .LENGTH_BITS(LEN_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Expected token records, oldest first
  tok_rec_t token_q[$];
  dir_row_t dir_tab[$];

  int fails      = 0;
  int n_in       = 0;
  int n_out      = 0;
  int items_done = 0;
  int src_pct    = 0;
  int sink_pct   = 0;
  int sink_hold  = 0;
  int idle_cyc   = 0;

  // Scanner state of the predictor
  stt_pkg::scan_mode_e lx_mode;
  logic [OFF_W-1:0]    lx_pos;
  logic [OFF_W-1:0]    lx_start;
  logic [LEN_W-1:0]    lx_len;
  logic                lx_sat;
  logic [1:0]          lx_kw_prog;
  logic                lx_kw_ok;

  // Records caused by the last scanned transaction
  tok_rec_t step_rec[2];
  int       step_n;
  logic     step_ignored;

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Append an expected record
  function automatic void exp_add(input tok_rec_t r);
    token_q.insert(token_q.size(), r);
  endfunction

  function automatic void lex_reset();
    lx_mode    = stt_pkg::MODE_IDLE;
    lx_pos     = '0;
    lx_start   = '0;
    lx_len     = '0;
    lx_sat     = 1'b0;
    lx_kw_prog = '0;
    lx_kw_ok   = 1'b0;
  endfunction

  function automatic void put_tok(input stt_pkg::token_kind_e kind,
                                  input logic [OFF_W-1:0] start,
                                  input logic [LEN_W-1:0] len, input logic sat,
                                  input stt_pkg::op_code_e op, input logic [7:0] bad);
    step_rec[step_n] = '{kind: kind, start: start, len: len, sat: sat, op: op, bad: bad,
                         last: 1'b0};
    step_n++;
  endfunction

  // Length saturates; overflow sticks until the next token
  function automatic void lex_grow();
    if (lx_len == {LEN_W{1'b1}}) lx_sat = 1'b1;
    else lx_len++;
  endfunction

  // Emit the pending number, identifier or string, if any
  function automatic void lex_flush();
    stt_pkg::token_kind_e kind;
    case (lx_mode)
      stt_pkg::MODE_NUMBER: kind = stt_pkg::KIND_NUMBER;
      stt_pkg::MODE_IDENT:  kind = (lx_kw_ok && lx_kw_prog == stt_pkg::KW_DONE) ?
                                   stt_pkg::KIND_KEYWORD : stt_pkg::KIND_IDENT;
      stt_pkg::MODE_STRING: kind = stt_pkg::KIND_STRING;
      default:              return;
    endcase
    put_tok(kind, lx_start, lx_len, lx_sat, stt_pkg::OP_PLUS, 8'h00);
    lx_mode = stt_pkg::MODE_IDLE;
  endfunction

  // Predict the records of one input transaction
  function automatic void lex_step(input logic [7:0] b, input logic eoi);
    logic [OFF_W-1:0] pos;
    step_n       = 0;
    step_ignored = 1'b0;
    if (eoi) begin
      lex_flush();
      if (step_n > 0) step_rec[step_n-1].last = 1'b1;
      lex_reset();
      return;
    end
    pos    = lx_pos;
    lx_pos = pos + 1'b1;

    // Extend or close the pending token
    case (lx_mode)
      stt_pkg::MODE_ERROR: begin
        step_ignored = 1'b1;
        return;
      end
      stt_pkg::MODE_NUMBER: begin
        if (is_dec(b)) begin
          lex_grow();
          return;
        end
        lex_flush();
      end
      stt_pkg::MODE_IDENT: begin
        if (is_letter(b) || is_dec(b)) begin
          lex_grow();
          if (lx_kw_ok && lx_kw_prog < stt_pkg::KW_DONE && b == KW_TEXT[8*lx_kw_prog +: 8])
            lx_kw_prog++;
          else
            lx_kw_ok = 1'b0;
          return;
        end
        lex_flush();
      end
      stt_pkg::MODE_STRING: begin
        if (b == stt_pkg::CH_QUOTE) begin
          lex_flush();
          step_rec[0].last = 1'b1;
        end else begin
          lex_grow();
        end
        return;
      end
      default: lx_mode = stt_pkg::MODE_IDLE;
    endcase

    // Scan the byte from idle
    if (!is_blank(b)) begin
      if (is_dec(b) || is_letter(b)) begin
        lx_mode    = is_dec(b) ? stt_pkg::MODE_NUMBER : stt_pkg::MODE_IDENT;
        lx_start   = pos;
        lx_len     = LEN_W'(1);
        lx_sat     = 1'b0;
        lx_kw_ok   = (b == KW_TEXT[7:0]);
        lx_kw_prog = {1'b0, lx_kw_ok};
      end else if (b == stt_pkg::CH_QUOTE) begin
        lx_mode  = stt_pkg::MODE_STRING;
        lx_start = pos + 1'b1;
        lx_len   = '0;
        lx_sat   = 1'b0;
      end else begin
        case (b)
          stt_pkg::CH_PLUS:
            put_tok(stt_pkg::KIND_OPERATOR, pos, LEN_W'(1), 1'b0, stt_pkg::OP_PLUS, 8'h00);
          stt_pkg::CH_MINUS:
            put_tok(stt_pkg::KIND_OPERATOR, pos, LEN_W'(1), 1'b0, stt_pkg::OP_MINUS, 8'h00);
          stt_pkg::CH_STAR:
            put_tok(stt_pkg::KIND_OPERATOR, pos, LEN_W'(1), 1'b0, stt_pkg::OP_TIMES, 8'h00);
          stt_pkg::CH_SLASH:
            put_tok(stt_pkg::KIND_OPERATOR, pos, LEN_W'(1), 1'b0, stt_pkg::OP_DIVIDE, 8'h00);
          stt_pkg::CH_LPAREN:
            put_tok(stt_pkg::KIND_LPAREN, pos, LEN_W'(1), 1'b0, stt_pkg::OP_PLUS, 8'h00);
          stt_pkg::CH_RPAREN:
            put_tok(stt_pkg::KIND_RPAREN, pos, LEN_W'(1), 1'b0, stt_pkg::OP_PLUS, 8'h00);
          stt_pkg::CH_SEMI:
            put_tok(stt_pkg::KIND_SEMICOLON, pos, LEN_W'(1), 1'b0, stt_pkg::OP_PLUS, 8'h00);
          stt_pkg::CH_COMMA:
            put_tok(stt_pkg::KIND_COMMA, pos, LEN_W'(1), 1'b0, stt_pkg::OP_PLUS, 8'h00);
          default: begin
            put_tok(stt_pkg::KIND_ERROR, pos, LEN_W'(1), 1'b0, stt_pkg::OP_PLUS, b);
            lx_mode = stt_pkg::MODE_ERROR;
          end
        endcase
      end
    end
    if (step_n > 0) step_rec[step_n-1].last = 1'b1;
  endfunction

  // Compare one output transaction with its expectation
  function automatic void check_tok(input tok_rec_t e);
    logic [OFF_W-1:0] a_start;
    logic [LEN_W-1:0] a_len;
    logic             a_sat;
    logic [1:0]       a_op;
    logic [7:0]       a_bad;
    logic [TDW-PAD_LSB-1:0] a_pad;
    a_start = m_axis_tdata[OFF_W-1:0];
    a_len   = m_axis_tdata[LEN_LSB +: LEN_W];
    a_sat   = m_axis_tdata[SAT_BIT];
    a_op    = m_axis_tdata[OP_LSB +: 2];
    a_bad   = m_axis_tdata[BAD_LSB +: 8];
    a_pad   = m_axis_tdata[TDW-1:PAD_LSB];
    if (m_axis_tuser !== e.kind) begin
      $error("token_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
      fails++;
    end
    if (a_start !== e.start) begin
      $error("start_offset: expected %0d, got %0d", e.start, a_start);
      fails++;
    end
    if (a_len !== e.len) begin
      $error("token_length: expected %0d, got %0d", e.len, a_len);
      fails++;
    end
    if (a_sat !== e.sat) begin
      $error("length_saturated: expected %0d, got %0d", e.sat, a_sat);
      fails++;
    end
    if (a_op !== e.op) begin
      $error("operator_code: expected %0d, got %0d", e.op, a_op);
      fails++;
    end
    if (a_bad !== e.bad) begin
      $error("offending_byte: expected 0x%02h, got 0x%02h", e.bad, a_bad);
      fails++;
    end
    if (m_axis_tlast !== e.last) begin
      $error("last_of_run: expected %0d, got %0d", e.last, m_axis_tlast);
      fails++;
    end
    if (a_pad !== '0) begin
      $error("tdata padding: expected 0, got 0x%0h", a_pad);
      fails++;
    end
  endfunction

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (token_q.size() == 0) begin
        $error("unexpected record: kind %0d, tdata 0x%0h", m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        check_tok(token_q.pop_front());
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready = 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= sink_pct);
      end
    end
  end

  // Offer one byte; predict its records once it is accepted
  task automatic send_byte(input logic [7:0] b, input logic eoi, input logic typed,
                           input tok_rec_t trec);
    while ($urandom_range(99) < src_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    n_in++;
    lex_step(b, eoi);
    if (!step_ignored) items_done++;
    if (typed) begin
      exp_add(trec);
    end else begin
      for (int i = 0; i < step_n; i++) exp_add(step_rec[i]);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eoi);
    send_byte(b, eoi, 1'b0, '0);
  endtask

  // Sender pause until every expected record is out
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (token_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic void add_row(input logic [7:0] b, input logic eoi);
    dir_tab.insert(dir_tab.size(), '{b: b, eoi: eoi, typed: 1'b0, exp: '0});
  endfunction

  // Single-byte token with its record written out
  function automatic void add_tok(input logic [7:0] b, input stt_pkg::token_kind_e kind,
                                  input logic [OFF_W-1:0] start, input stt_pkg::op_code_e op,
                                  input logic [7:0] bad);
    dir_tab.insert(dir_tab.size(), '{b: b, eoi: 1'b0, typed: 1'b1,
                   exp: '{kind: kind, start: start, len: LEN_W'(1), sat: 1'b0, op: op,
                          bad: bad, last: 1'b1}});
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(4) == 0) ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : 8'(8'h09 + r);
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] c;
    case ($urandom_range(7))
      0:       c = stt_pkg::CH_PLUS;
      1:       c = stt_pkg::CH_MINUS;
      2:       c = stt_pkg::CH_STAR;
      3:       c = stt_pkg::CH_SLASH;
      4:       c = stt_pkg::CH_LPAREN;
      5:       c = stt_pkg::CH_RPAREN;
      6:       c = stt_pkg::CH_SEMI;
      default: c = stt_pkg::CH_COMMA;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_str_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == stt_pkg::CH_QUOTE);
    return c;
  endfunction

  // One random lexeme, mostly well formed
  task automatic send_random_token();
    int    sel;
    int    n;
    string w;
    sel = $urandom_range(99);
    if (sel < 15) begin
      n = ($urandom_range(99) == 0) ? 260 : $urandom_range(1, 6);
      repeat (n) push_byte(rand_digit(), 1'b0);
    end else if (sel < 35) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0:       w = "fun";
          1:       w = "fu";
          2:       w = "f";
          3:       w = "funk";
          4:       w = "fUn";
          default: w = "fun7";
        endcase
        for (int i = 0; i < w.len(); i++) push_byte(w[i], 1'b0);
      end else begin
        push_byte(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 7)) push_byte(rand_alnum(), 1'b0);
      end
    end else if (sel < 45) begin
      // string; now and then left open
      push_byte(stt_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 8)) push_byte(rand_str_byte(), 1'b0);
      if ($urandom_range(9) != 0) push_byte(stt_pkg::CH_QUOTE, 1'b0);
    end else if (sel < 70) begin
      push_byte(rand_punct(), 1'b0);
    end else if (sel < 85) begin
      repeat ($urandom_range(1, 3)) push_byte(rand_blank(), 1'b0);
    end else if (sel < 90) begin
      push_byte(8'($urandom_range(255)), 1'b1);
    end else if (sel < 96) begin
      push_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      push_byte(8'($urandom_range(128, 255)), 1'b0);
    end
    if ($urandom_range(9) < 3) push_byte(rand_blank(), 1'b0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    lex_reset();

    // Directed table
    add_row(8'hFF, 1'b1);                                   // end marker while idle
    add_tok(stt_pkg::CH_PLUS,   stt_pkg::KIND_OPERATOR,  0, stt_pkg::OP_PLUS,   8'h00);
    add_tok(stt_pkg::CH_MINUS,  stt_pkg::KIND_OPERATOR,  1, stt_pkg::OP_MINUS,  8'h00);
    add_tok(stt_pkg::CH_STAR,   stt_pkg::KIND_OPERATOR,  2, stt_pkg::OP_TIMES,  8'h00);
    add_tok(stt_pkg::CH_SLASH,  stt_pkg::KIND_OPERATOR,  3, stt_pkg::OP_DIVIDE, 8'h00);
    add_tok(stt_pkg::CH_LPAREN, stt_pkg::KIND_LPAREN,    4, stt_pkg::OP_PLUS,   8'h00);
    add_tok(stt_pkg::CH_RPAREN, stt_pkg::KIND_RPAREN,    5, stt_pkg::OP_PLUS,   8'h00);
    add_tok(stt_pkg::CH_SEMI,   stt_pkg::KIND_SEMICOLON, 6, stt_pkg::OP_PLUS,   8'h00);
    add_tok(stt_pkg::CH_COMMA,  stt_pkg::KIND_COMMA,     7, stt_pkg::OP_PLUS,   8'h00);
    add_row(8'h31, 1'b0);                                   // "19" ended by a letter
    add_row(8'h39, 1'b0);
    add_row(8'h66, 1'b0);                                   // "fun" then "(": two records
    add_row(8'h75, 1'b0);
    add_row(8'h6E, 1'b0);
    add_row(stt_pkg::CH_LPAREN, 1'b0);
    add_row(stt_pkg::CH_QUOTE, 1'b0);                       // empty string
    add_row(stt_pkg::CH_QUOTE, 1'b0);
    add_row(8'h5A, 1'b0);                                   // ident ended by an error byte
    add_row(8'hFF, 1'b0);
    add_row(8'h61, 1'b0);                                   // ignored in error mode
    add_row(8'h00, 1'b1);
    add_tok(8'h80, stt_pkg::KIND_ERROR, 0, stt_pkg::OP_PLUS, 8'h80);
    add_row(8'h00, 1'b1);                                   // no record from error mode
    add_row(stt_pkg::CH_QUOTE, 1'b0);                       // string closed by end marker
    add_row(8'h78, 1'b0);
    add_row(8'h00, 1'b1);
    add_row(8'h09, 1'b0);                                   // ident flushed by end marker
    add_row(8'h7A, 1'b0);
    add_row(8'hFF, 1'b1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].eoi, dir_tab[i].typed,
                                   dir_tab[i].exp);
    wait_drained();

    // Length saturation: a number one past the maximum, a string at the maximum
    push_byte(8'h00, 1'b1);
    repeat (256) push_byte(rand_digit(), 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(stt_pkg::CH_QUOTE, 1'b0);
    repeat (255) push_byte(rand_str_byte(), 1'b0);
    push_byte(stt_pkg::CH_QUOTE, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_drained();

    // Random traffic under four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_pct = 0;  sink_pct = 0;  end
        1:       begin src_pct = 54; sink_pct = 0;  end
        2:       begin src_pct = 0;  sink_pct = 54; end
        default: begin src_pct = 12; sink_pct = 12; end
      endcase
      if (ph == 0) begin
        // receiver holds off while the sender keeps offering
        sink_hold = HOLD_CYCLES;
        repeat (40) push_byte(rand_punct(), 1'b0);
      end
      items_done = 0;
      while (items_done < RAND_ITEMS) send_random_token();
      wait_drained();
    end

    if (token_q.size() != 0) begin
      $error("%0d expected records never arrived", token_q.size());
      fails++;
    end
    $display("summary: %0d input transactions, %0d token records checked,", n_in, n_out);
    $display("summary: directed table, length saturation, four idling mixes");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
